// ===== rtl/core/ofb_pkg.sv =====
// Shared types and constants for the OLED page frame store engine.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ofb_pkg;

  // Panel geometry.
  localparam int COLUMNS     = 130;
  localparam int ROWS        = 64;
  localparam int PAGES       = (ROWS + 7) / 8;
  localparam int STORE_BYTES = COLUMNS * PAGES;

  // Refresh stream layout: four command bytes, a data control byte, then the columns.
  localparam int HDR_BYTES   = 5;
  localparam int PAGE_STREAM = HDR_BYTES + COLUMNS;

  localparam int ADDR_W  = $clog2(STORE_BYTES);
  localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int OFF_W   = $clog2(PAGE_STREAM);
  localparam int COORD_W = 9;
  localparam int BYTE_W  = 8;

  // Byte positions inside one page's stream.
  localparam logic [OFF_W-1:0] OFF_CMD_CTL = OFF_W'(0);
  localparam logic [OFF_W-1:0] OFF_PAGE    = OFF_W'(1);
  localparam logic [OFF_W-1:0] OFF_COL_LO  = OFF_W'(2);
  localparam logic [OFF_W-1:0] OFF_COL_HI  = OFF_W'(3);
  localparam logic [OFF_W-1:0] OFF_DAT_CTL = OFF_W'(4);
  localparam logic [OFF_W-1:0] OFF_LAST    = OFF_W'(PAGE_STREAM - 1);

  // Panel command bytes.
  localparam logic [BYTE_W-1:0] PAGE_CMD_BASE = 8'hB0;
  localparam logic [BYTE_W-1:0] COL_LO_CMD    = 8'h00;
  localparam logic [BYTE_W-1:0] COL_HI_CMD    = 8'h10;
  localparam logic [BYTE_W-1:0] BYTE_ONES     = 8'hFF;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_CTL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DAT_CTL = 3'd4;

  localparam logic [BYTE_W-1:0] DAT_CTL_RESET = 8'h40;

  typedef enum logic [1:0] {
    OP_DRAW    = 2'd0,
    OP_FILL    = 2'd1,
    OP_REFRESH = 2'd2
  } ofb_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW_WR,
    ST_FILL,
    ST_REF_OUT
  } ofb_state_t;

  typedef struct packed {
    logic sweep_start;
    logic sweep_wr;
    logic draw_rd;
    logic draw_wr;
    logic ref_rd;
    logic load_out;
  } ofb_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic out_free;
  } ofb_sts_t;

endpackage

// ===== rtl/core/ofb_if.sv =====
// Valid/ready channel interfaces: item input, refresh byte output, register writes.
// Depends on ofb_pkg for the field widths.
`timescale 1ns / 1ps

interface ofb_in_if import ofb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [BYTE_W-1:0] x_coord;
  logic [BYTE_W-1:0] y_coord;
  logic              pixel_color;

  modport source (output valid, opcode, x_coord, y_coord, pixel_color, input ready);
  modport sink   (input valid, opcode, x_coord, y_coord, pixel_color, output ready);
endinterface

interface ofb_out_if import ofb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              first_of_transfer;
  logic              last_of_transfer;
  logic              last_of_frame;

  modport source (output valid, out_byte, first_of_transfer, last_of_transfer, last_of_frame,
                  input ready);
  modport sink   (input valid, out_byte, first_of_transfer, last_of_transfer, last_of_frame,
                  output ready);
endinterface

interface ofb_cfg_if import ofb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ofb_ctrl.sv =====
// Controller state machine: sequences draws, fills, refresh reads and the reset clear.
// Depends on ofb_pkg; drives the datapath only through ofb_cmd_t and reads ofb_sts_t.
`timescale 1ns / 1ps

module ofb_ctrl import ofb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_opcode,
  output logic       in_ready,
  input  ofb_sts_t   sts,
  output ofb_cmd_t   cmd
);

  ofb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (ofb_op_t'(in_opcode))
            OP_DRAW: begin
              cmd.draw_rd = 1'b1;
              state_nxt   = ST_DRAW_WR;
            end
            OP_FILL: begin
              cmd.sweep_start = 1'b1;
              state_nxt       = ST_FILL;
            end
            OP_REFRESH: begin
              cmd.ref_rd = 1'b1;
              state_nxt  = ST_REF_OUT;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_DRAW_WR: begin
        cmd.draw_wr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_CLEAR, ST_FILL: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REF_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ofb_dp.sv =====
// Datapath: frame store memory, configuration registers, refresh position and output register.
// Depends on ofb_pkg; acts on the command struct from ofb_ctrl.
`timescale 1ns / 1ps

module ofb_dp import ofb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ofb_cmd_t             cmd,
  output ofb_sts_t             sts,
  input  logic [BYTE_W-1:0]    in_x_coord,
  input  logic [BYTE_W-1:0]    in_y_coord,
  input  logic                 in_pixel_color,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_first,
  output logic                 out_last,
  output logic                 out_last_frame
);

  logic [BYTE_W-1:0] mem [0:STORE_BYTES-1];

  logic              invert_r;
  logic [BYTE_W-1:0] x_off_r, y_off_r, cmd_ctl_r, dat_ctl_r;

  logic [COORD_W-1:0] px, py;
  logic               draw_hit;
  logic [PAGE_W-1:0]  draw_page;
  logic [ADDR_W-1:0]  draw_addr;

  logic [ADDR_W-1:0] d_addr_r;
  logic              d_hit_r;
  logic [2:0]        d_bit_r;
  logic              d_color_r;
  logic [BYTE_W-1:0] d_mask, d_byte;

  logic [PAGE_W-1:0] ref_page_r;
  logic [OFF_W-1:0]  ref_off_r;
  logic [OFF_W-1:0]  ref_col;
  logic [ADDR_W-1:0] ref_addr;
  logic              ref_data_phase;

  logic [ADDR_W-1:0] sw_cnt_r;
  logic [BYTE_W-1:0] fill_r;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data_r;

  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r, hdr_byte;
  logic              out_first_r, out_last_r, out_last_frame_r;
  logic              hdr_first, hdr_last, hdr_last_frame;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r  <= 1'b0;
      x_off_r   <= '0;
      y_off_r   <= '0;
      cmd_ctl_r <= '0;
      dat_ctl_r <= DAT_CTL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INVERT:  invert_r  <= cfg_data[0];
        CFG_X_OFF:   x_off_r   <= cfg_data;
        CFG_Y_OFF:   y_off_r   <= cfg_data;
        CFG_CMD_CTL: cmd_ctl_r <= cfg_data;
        CFG_DAT_CTL: dat_ctl_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Draw address: offsets are added at nine bits so that no sum wraps.
  assign px        = {1'b0, in_x_coord} + {1'b0, x_off_r};
  assign py        = {1'b0, in_y_coord} + {1'b0, y_off_r};
  assign draw_hit  = (px < COORD_W'(COLUMNS)) && (py < COORD_W'(ROWS));
  assign draw_page = PAGE_W'(py >> 3);
  assign draw_addr = ADDR_W'(ADDR_W'(draw_page) * ADDR_W'(COLUMNS)) + ADDR_W'(px);

  always_ff @(posedge clk) begin
    if (cmd.draw_rd) begin
      d_addr_r  <= draw_addr;
      d_hit_r   <= draw_hit;
      d_bit_r   <= py[2:0];
      d_color_r <= in_pixel_color ^ invert_r;
    end
  end

  assign d_mask = BYTE_W'(1) << d_bit_r;
  assign d_byte = d_color_r ? (rd_data_r | d_mask) : (rd_data_r & ~d_mask);

  // Refresh position kept as page and byte-in-page, so no division is needed.
  assign ref_data_phase = ref_off_r >= OFF_W'(HDR_BYTES);
  assign ref_col        = ref_off_r - OFF_W'(HDR_BYTES);
  assign ref_addr       = ADDR_W'(ADDR_W'(ref_page_r) * ADDR_W'(COLUMNS)) + ADDR_W'(ref_col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_page_r <= '0;
      ref_off_r  <= '0;
    end else if (cmd.load_out) begin
      if (ref_off_r == OFF_LAST) begin
        ref_off_r <= '0;
        if (ref_page_r == PAGE_W'(PAGES - 1)) begin
          ref_page_r <= '0;
        end else begin
          ref_page_r <= ref_page_r + PAGE_W'(1);
        end
      end else begin
        ref_off_r <= ref_off_r + OFF_W'(1);
      end
    end
  end

  // Sweep counter for the reset clear and for fills.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_cnt_r <= '0;
      fill_r   <= '0;
    end else if (cmd.sweep_start) begin
      sw_cnt_r <= '0;
      fill_r   <= in_pixel_color ? BYTE_ONES : '0;
    end else if (cmd.sweep_wr) begin
      if (sts.sweep_last) begin
        sw_cnt_r <= '0;
      end else begin
        sw_cnt_r <= sw_cnt_r + ADDR_W'(1);
      end
    end
  end

  assign sts.sweep_last = sw_cnt_r == ADDR_W'(STORE_BYTES - 1);

  // Frame store: one write port, one registered read port.
  assign rd_en   = (cmd.draw_rd && draw_hit) || (cmd.ref_rd && ref_data_phase);
  assign rd_addr = cmd.draw_rd ? draw_addr : ref_addr;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_wr) begin
      mem[sw_cnt_r] <= fill_r;
    end else if (cmd.draw_wr && d_hit_r) begin
      mem[d_addr_r] <= d_byte;
    end
  end

  // Stream byte selection.
  always_comb begin
    hdr_first      = 1'b0;
    hdr_last       = 1'b0;
    hdr_last_frame = 1'b0;
    case (ref_off_r)
      OFF_CMD_CTL: begin
        hdr_byte  = cmd_ctl_r;
        hdr_first = 1'b1;
      end
      OFF_PAGE:    hdr_byte = PAGE_CMD_BASE + BYTE_W'(ref_page_r);
      OFF_COL_LO:  hdr_byte = COL_LO_CMD;
      OFF_COL_HI: begin
        hdr_byte = COL_HI_CMD;
        hdr_last = 1'b1;
      end
      OFF_DAT_CTL: begin
        hdr_byte  = dat_ctl_r;
        hdr_first = 1'b1;
      end
      default: begin
        hdr_byte = rd_data_r;
        if (ref_off_r == OFF_LAST) begin
          hdr_last       = 1'b1;
          hdr_last_frame = ref_page_r == PAGE_W'(PAGES - 1);
        end
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_byte_r       <= hdr_byte;
      out_first_r      <= hdr_first;
      out_last_r       <= hdr_last;
      out_last_frame_r <= hdr_last_frame;
    end
  end

  assign sts.out_free   = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign out_first      = out_first_r;
  assign out_last       = out_last_r;
  assign out_last_frame = out_last_frame_r;

endmodule

// ===== rtl/core/oled_page_framebuffer_engine.sv =====
// Top level of the OLED page frame store engine; joins ofb_ctrl and ofb_dp (uses ofb_pkg, ofb_if).
// Draw: read on accept, then the changed byte is written back in ST_DRAW_WR through the write port.
// Refresh: read on accept, then loaded into the output register in ST_REF_OUT once that is free.
// Fill: the sweep counter writes all STORE_BYTES (1040) bytes, one byte per cycle.
// Reset: synchronous, active low; a clearing sweep of STORE_BYTES (1040) bytes follows, input held off.
`timescale 1ns / 1ps

module oled_page_framebuffer_engine import ofb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ofb_in_if.sink    in_if,
  ofb_out_if.source out_if,
  ofb_cfg_if.sink   cfg_if
);

  // The controller and datapath talk only through these two structs.
  ofb_cmd_t cmd;
  ofb_sts_t sts;

  // The controller decides what happens with each input transfer. It accepts a new
  // item only while idle, which makes every item see the store exactly as the
  // previous item left it.
  ofb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_opcode (in_if.opcode),
    .in_ready  (in_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the frame store, the register file, the refresh position
  // and the output register. A refresh result can wait in the output register
  // while the next draw or fill item is already taken.
  ofb_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_x_coord     (in_if.x_coord),
    .in_y_coord     (in_if.y_coord),
    .in_pixel_color (in_if.pixel_color),
    .cfg_valid      (cfg_if.valid),
    .cfg_ready      (cfg_if.ready),
    .cfg_index      (cfg_if.index),
    .cfg_data       (cfg_if.data),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_byte       (out_if.out_byte),
    .out_first      (out_if.first_of_transfer),
    .out_last       (out_if.last_of_transfer),
    .out_last_frame (out_if.last_of_frame)
  );

`ifndef SYNTHESIS
  // No input item may be taken while the store is being swept.
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep_wr |-> !in_if.ready)
    else $error("input accepted during a store sweep");

  // A result is loaded only when the output register is free or being drained.
  a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_if.valid || out_if.ready))
    else $error("output register overwritten");

  // The write half of a draw always follows its read half.
  a_draw_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.draw_wr |-> $past(cmd.draw_rd))
    else $error("draw write without a preceding read");
`endif

endmodule

// ===== tb/tb_oled_page_framebuffer_engine.sv =====
// Self-checking testbench for oled_page_framebuffer_engine: directed script, then random phases.
// Depends on ofb_pkg and the channel interfaces in ofb_if; a local frame store model predicts bytes.
`timescale 1ns / 1ps

module tb_oled_page_framebuffer_engine;
  import ofb_pkg::*;

  // One full frame of the refresh stream, headers included.
  localparam int FRAME_BYTES = PAGES * PAGE_STREAM;

  // Opcode 3 has no function; the engine must swallow it without a result.
  localparam logic [1:0] OP_SPARE = 2'd3;

  // A fill sweeps the whole store, so a register write waits at least that long after the
  // last input transfer. Draws and fills never produce a byte, so there is no handshake to
  // tell us they are done.
  localparam int DRAIN_CYCLES = STORE_BYTES + 64;
  localparam int TAIL_CYCLES  = 32;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 10;
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              first;
    logic              last;
    logic              frame_end;
  } refresh_byte_t;

  // Directed script row. When known is set, the expected byte is the one typed here
  // rather than the one the frame store model computes.
  typedef struct packed {
    logic [1:0]        op;
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] y;
    logic              color;
    logic              known;
    refresh_byte_t     want;
  } script_row_t;

  // One random phase: the register setting it runs under and the shape of its traffic.
  typedef struct packed {
    logic              invert;
    logic [BYTE_W-1:0] x_off;
    logic [BYTE_W-1:0] y_off;
    logic [BYTE_W-1:0] cmd_ctl;
    logic [BYTE_W-1:0] dat_ctl;
    logic [15:0]       items;
    logic [7:0]        refresh_pct;
    logic              shuffle;
    logic              no_idle;
    logic              hold;
  } phase_t;

  // The directed part runs right after reset with the power-on register values: command
  // control 0x00, data control 0x40, no offsets, no inversion. The first five refreshes
  // walk the command transfer and the data control byte of page 0; the rest read columns
  // of page 0 in order, so every typed byte can be read straight off the draws and fills above it.
  localparam int NUM_SCRIPT = 25;
  localparam script_row_t SCRIPT [NUM_SCRIPT] = '{
    '{OP_REFRESH, 8'd0,   8'd0,   1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
    '{OP_REFRESH, 8'd255, 8'd255, 1'b1, 1'b1, '{8'hB0, 1'b0, 1'b0, 1'b0}},
    '{OP_REFRESH, 8'd0,   8'd0,   1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_REFRESH, 8'd0,   8'd0,   1'b0, 1'b1, '{8'h10, 1'b0, 1'b1, 1'b0}},
    '{OP_REFRESH, 8'd0,   8'd0,   1'b0, 1'b1, '{8'h40, 1'b1, 1'b0, 1'b0}},
    '{OP_DRAW,    8'd0,   8'd0,   1'b1, 1'b0, '0},
    '{OP_DRAW,    8'd129, 8'd63,  1'b1, 1'b0, '0},
    '{OP_DRAW,    8'd130, 8'd0,   1'b1, 1'b0, '0},
    '{OP_DRAW,    8'd0,   8'd64,  1'b1, 1'b0, '0},
    '{OP_DRAW,    8'd255, 8'd255, 1'b1, 1'b0, '0},
    '{OP_DRAW,    8'd1,   8'd7,   1'b1, 1'b0, '0},
    '{OP_REFRESH, 8'd0,   8'd0,   1'b0, 1'b1, '{8'h01, 1'b0, 1'b0, 1'b0}},
    '{OP_REFRESH, 8'd0,   8'd0,   1'b0, 1'b1, '{8'h80, 1'b0, 1'b0, 1'b0}},
    '{OP_DRAW,    8'd3,   8'd2,   1'b1, 1'b0, '0},
    '{OP_DRAW,    8'd2,   8'd5,   1'b1, 1'b0, '0},
    '{OP_DRAW,    8'd2,   8'd5,   1'b0, 1'b0, '0},
    '{OP_REFRESH, 8'd0,   8'd0,   1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_REFRESH, 8'd0,   8'd0,   1'b0, 1'b1, '{8'h04, 1'b0, 1'b0, 1'b0}},
    '{OP_SPARE,   8'd255, 8'd255, 1'b1, 1'b0, '0},
    '{OP_FILL,    8'd255, 8'd0,   1'b1, 1'b0, '0},
    '{OP_REFRESH, 8'd0,   8'd0,   1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b0}},
    '{OP_FILL,    8'd0,   8'd255, 1'b0, 1'b0, '0},
    '{OP_REFRESH, 8'd0,   8'd0,   1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0}},
    '{OP_DRAW,    8'd6,   8'd0,   1'b1, 1'b0, '0},
    '{OP_REFRESH, 8'd0,   8'd0,   1'b0, 1'b0, '0}
  };

  // Random phases. The second one uses the largest offsets and command control byte, so every
  // draw falls off the panel; the fourth leaves exactly one visible pixel, the bottom-right
  // corner. The third is refresh-heavy and carries the long receiver hold-off. Phases
  // marked shuffle pick a fresh register setting at random.
  localparam int NUM_PHASES = 6;
  localparam phase_t PHASES [NUM_PHASES] = '{
    '{1'b0, 8'd0,   8'd0,   8'h00, 8'h40, 16'd250, 8'd75, 1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd255, 8'd255, 8'hFF, 8'h00, 16'd150, 8'd60, 1'b0, 1'b0, 1'b0},
    '{1'b1, 8'd0,   8'd0,   8'h5A, 8'hA5, 16'd400, 8'd90, 1'b0, 1'b0, 1'b1},
    '{1'b0, 8'd129, 8'd63,  8'h3C, 8'hC3, 16'd150, 8'd60, 1'b0, 1'b0, 1'b0},
    '{1'b0, 8'd0,   8'd0,   8'h00, 8'h00, 16'd300, 8'd75, 1'b1, 1'b1, 1'b0},
    '{1'b0, 8'd0,   8'd0,   8'h00, 8'h00, 16'd300, 8'd75, 1'b1, 1'b0, 1'b0}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ofb_in_if  in_ch  ();
  ofb_out_if out_ch ();
  ofb_cfg_if cfg_ch ();

  oled_page_framebuffer_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #5ns clk = ~clk;

  // Frame store model: its own copy of the store, the scan position and the registers.
  logic [BYTE_W-1:0] panel_mem [STORE_BYTES];
  int unsigned       scan_pos;
  logic              invert_q;
  logic [BYTE_W-1:0] x_off_q;
  logic [BYTE_W-1:0] y_off_q;
  logic [BYTE_W-1:0] cmd_ctl_q;
  logic [BYTE_W-1:0] dat_ctl_q;

  // Refresh bytes still owed by the engine, oldest first.
  refresh_byte_t refresh_due [$];

  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  bit          no_idle     = 1'b0;
  bit          hold_req    = 1'b0;

  function automatic void note_failure(input string text);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", text);
  endfunction

  function automatic void panel_reset();
    foreach (panel_mem[i]) panel_mem[i] = '0;
    scan_pos  = 0;
    invert_q  = 1'b0;
    x_off_q   = '0;
    y_off_q   = '0;
    cmd_ctl_q = '0;
    dat_ctl_q = DAT_CTL_RESET;
  endfunction

  function automatic void panel_config(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [BYTE_W-1:0] val);
    case (idx)
      CFG_INVERT:  invert_q  = val[0];
      CFG_X_OFF:   x_off_q   = val;
      CFG_Y_OFF:   y_off_q   = val;
      CFG_CMD_CTL: cmd_ctl_q = val;
      CFG_DAT_CTL: dat_ctl_q = val;
      default: ;
    endcase
  endfunction

  // Applies one input item to the model. Returns 1 and the byte when the item is a refresh.
  function automatic bit panel_apply(input logic [1:0] op, input logic [BYTE_W-1:0] x,
                                     input logic [BYTE_W-1:0] y, input logic color,
                                     output refresh_byte_t res);
    int unsigned px, py, page, off;
    res = '0;
    panel_apply = 1'b0;
    case (op)
      OP_DRAW: begin
        // The offset sums are taken at full width, so a large offset never wraps back in.
        px = int'(x) + int'(x_off_q);
        py = int'(y) + int'(y_off_q);
        if (px < COLUMNS && py < ROWS)
          panel_mem[(py / 8) * COLUMNS + px][py % 8] = color ^ invert_q;
      end
      OP_FILL: begin
        // Fill takes the color as given; inversion only applies to pixel draws.
        foreach (panel_mem[i]) panel_mem[i] = color ? BYTE_ONES : 8'h00;
      end
      OP_REFRESH: begin
        page = scan_pos / PAGE_STREAM;
        off  = scan_pos % PAGE_STREAM;
        if (off == OFF_CMD_CTL) begin
          res.data  = cmd_ctl_q;
          res.first = 1'b1;
        end else if (off == OFF_PAGE) begin
          res.data = PAGE_CMD_BASE + BYTE_W'(page);
        end else if (off == OFF_COL_LO) begin
          res.data = COL_LO_CMD;
        end else if (off == OFF_COL_HI) begin
          res.data = COL_HI_CMD;
          res.last = 1'b1;
        end else if (off == OFF_DAT_CTL) begin
          res.data  = dat_ctl_q;
          res.first = 1'b1;
        end else begin
          // Column bytes read the store as it is now, so draws made mid-frame show up.
          res.data      = panel_mem[page * COLUMNS + off - HDR_BYTES];
          res.last      = (off == OFF_LAST);
          res.frame_end = res.last && (page == PAGES - 1);
        end
        scan_pos    = (scan_pos + 1) % FRAME_BYTES;
        panel_apply = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Offers one item after a random gap and holds it until the engine takes it. Valid is
  // only lowered when a gap follows, so back-to-back items keep it high without a glitch.
  task automatic send_item(input logic [1:0] op, input logic [BYTE_W-1:0] x,
                           input logic [BYTE_W-1:0] y, input logic color,
                           input logic known, input refresh_byte_t want);
    int unsigned   gap;
    refresh_byte_t res;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.x_coord     <= x;
    in_ch.y_coord     <= y;
    in_ch.pixel_color <= color;
    do @(posedge clk); while (!in_ch.ready);
    // The transfer happened at this edge; the model advances in acceptance order.
    if (panel_apply(op, x, y, color, res)) refresh_due.push_back(known ? want : res);
  endtask

  task automatic send_random(input int refresh_pct);
    int unsigned       roll;
    int                x_top, y_top;
    logic [1:0]        op;
    logic [BYTE_W-1:0] x, y;
    logic              color;
    roll  = $urandom_range(0, 99);
    x     = 8'($urandom_range(0, 255));
    y     = 8'($urandom_range(0, 255));
    color = 1'($urandom_range(0, 1));
    if (roll < refresh_pct) begin
      op = OP_REFRESH;
    end else if (roll < refresh_pct + 2) begin
      op = OP_FILL;
    end else if (roll < refresh_pct + 5) begin
      op = OP_SPARE;
    end else begin
      op = OP_DRAW;
      // Most draws are aimed inside the panel after the offsets, so the refresh stream
      // actually shows them; the rest keep the full coordinate range and mostly drop.
      x_top = COLUMNS - 1 - int'(x_off_q);
      y_top = ROWS - 1 - int'(y_off_q);
      if ($urandom_range(0, 9) < 7 && x_top >= 0 && y_top >= 0) begin
        x = 8'($urandom_range(0, x_top));
        y = 8'($urandom_range(0, y_top));
      end
    end
    send_item(op, x, y, color, 1'b0, '0);
  endtask

  // Writes all five registers in index order, one transfer each.
  task automatic write_config(input logic invert, input logic [BYTE_W-1:0] x_off,
                              input logic [BYTE_W-1:0] y_off, input logic [BYTE_W-1:0] cmd_ctl,
                              input logic [BYTE_W-1:0] dat_ctl);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [BYTE_W-1:0]    val [5];
    idx[0] = CFG_INVERT;  val[0] = {7'd0, invert};
    idx[1] = CFG_X_OFF;   val[1] = x_off;
    idx[2] = CFG_Y_OFF;   val[2] = y_off;
    idx[3] = CFG_CMD_CTL; val[3] = cmd_ctl;
    idx[4] = CFG_DAT_CTL; val[4] = dat_ctl;
    for (int i = 0; i < 5; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= val[i];
      do @(posedge clk); while (!cfg_ch.ready);
      panel_config(idx[i], val[i]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Brings the engine to rest: no input pending, every owed byte received, and enough
  // further cycles for a trailing draw or fill to finish.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (refresh_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result receiver. Unless no_idle is set, it stalls for a random number of cycles before each
  // transfer. When the main thread asks for a hold-off, it keeps ready low for a long stretch
  // instead, while the sender keeps offering refreshes, so the engine backs up into its input.
  initial begin : refresh_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Every byte that crosses the output channel is matched against the oldest owed byte.
  always @(posedge clk) begin : refresh_check
    refresh_byte_t got;
    refresh_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_byte, out_ch.first_of_transfer, out_ch.last_of_transfer,
              out_ch.last_of_frame};
      if (refresh_due.size() == 0) begin
        note_failure($sformatf("[%0t] unexpected refresh byte %02h first=%b last=%b frame=%b",
                               $realtime, got.data, got.first, got.last, got.frame_end));
      end else begin
        want = refresh_due.pop_front();
        if (got.data !== want.data || got.first !== want.first || got.last !== want.last ||
            got.frame_end !== want.frame_end)
          note_failure($sformatf(
            "[%0t] refresh byte mismatch: expected %02h/%b/%b/%b, got %02h/%b/%b/%b",
            $realtime, want.data, want.first, want.last, want.frame_end,
            got.data, got.first, got.last, got.frame_end));
      end
    end
  end

  // Watchdog: a hung handshake or a byte that never arrives ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.opcode      <= OP_DRAW;
    in_ch.x_coord     <= '0;
    in_ch.y_coord     <= '0;
    in_ch.pixel_color <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= CFG_INVERT;
    cfg_ch.data       <= '0;
    panel_reset();

    // Reset is held low from time zero and released once. The engine then clears its store
    // on its own; input transfers simply wait for ready.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_SCRIPT; i++)
      send_item(SCRIPT[i].op, SCRIPT[i].x, SCRIPT[i].y, SCRIPT[i].color,
                SCRIPT[i].known, SCRIPT[i].want);

    // Register writes only happen with the engine at rest. The random phases together run
    // well over one frame, so the end-of-frame byte and the wrap to page 0 are exercised.
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (PHASES[p].shuffle)
        write_config(1'($urandom_range(0, 1)), 8'($urandom_range(0, 40)),
                     8'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
      else
        write_config(PHASES[p].invert, PHASES[p].x_off, PHASES[p].y_off,
                     PHASES[p].cmd_ctl, PHASES[p].dat_ctl);
      no_idle  = PHASES[p].no_idle;
      hold_req = PHASES[p].hold;
      repeat (PHASES[p].items) send_random(int'(PHASES[p].refresh_pct));
    end

    in_ch.valid <= 1'b0;
    while (refresh_due.size() != 0) @(posedge clk);
    // A few more cycles to catch a stray byte after the last expected one.
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
